FILE: design/pcm_pkg.sv
// Package for the predecessor claim multiset unit.
// Holds sizes, status codes, payload structs and controller/datapath structs.
// No dependencies.
package pcm_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int VAL_W    = 32;

  // Result status codes.
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MATCHED = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLAIM  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] result_value;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       srch_rd;
    logic       srch_cmp;
    logic       cur_init;
    logic       sh_rd;
    logic       sh_wr;
    logic       cl_rd;
    logic       cl_cap;
    logic       finish;
    logic       set_st;
    logic [1:0] st_code;
  } pcm_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic full;
    logic more;
    logic lo_zero;
    logic shift_more;
  } pcm_sts_t;

endpackage

FILE: design/pcm_ram.sv
// Generic simple dual-port RAM with a registered read port.
// One write and one read address per cycle. No dependencies.
module pcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/pcm_datapath.sv
// Datapath of the predecessor claim multiset unit: value table, search bounds,
// shift cursor, stored count and result registers. Depends on pcm_pkg, pcm_ram.
module pcm_datapath
  import pcm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  input  pcm_ctl_t ctl_i,
  output pcm_sts_t sts_o,
  output res_t     result_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, cursor_q, cursor_d;
  logic [IDX_W-1:0] mid_q, mid_d;
  logic             op_q, op_d;
  logic [VAL_W-1:0] val_q, val_d, res_q, res_d;
  logic [1:0]       status_q, status_d;

  logic [CNT_W-1:0] mid_w, cur_m1, cur_p1, lo_m1;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;

  assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);
  assign cur_m1 = cursor_q - 1'b1;
  assign cur_p1 = cursor_q + 1'b1;
  assign lo_m1  = lo_q - 1'b1;

  // Table port addressing.
  always_comb begin
    raddr = '0;
    if (ctl_i.srch_rd) begin
      raddr = mid_w[IDX_W-1:0];
    end else if (ctl_i.sh_rd) begin
      raddr = op_q ? cursor_q[IDX_W-1:0] : cur_m1[IDX_W-1:0];
    end else if (ctl_i.cl_rd) begin
      raddr = lo_m1[IDX_W-1:0];
    end
  end

  assign we    = ctl_i.sh_wr || (ctl_i.finish && (op_q == OP_INSERT));
  assign waddr = ctl_i.sh_wr ? (op_q ? cur_m1[IDX_W-1:0] : cursor_q[IDX_W-1:0])
                             : lo_q[IDX_W-1:0];
  assign wdata = ctl_i.sh_wr ? rdata : val_q;

  pcm_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next-state logic of the working registers.
  always_comb begin
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cursor_d = cursor_q;
    mid_d    = mid_q;
    op_d     = op_q;
    val_d    = val_q;
    res_d    = res_q;
    status_d = status_q;
    if (ctl_i.load) begin
      op_d  = cmd_i.operation;
      val_d = cmd_i.value;
      lo_d  = '0;
      hi_d  = count_q;
      res_d = '0;
    end
    if (ctl_i.srch_rd) begin
      mid_d = mid_w[IDX_W-1:0];
    end
    if (ctl_i.srch_cmp) begin
      if (rdata <= val_q) begin
        lo_d = {1'b0, mid_q} + 1'b1;
      end else begin
        hi_d = {1'b0, mid_q};
      end
    end
    if (ctl_i.cur_init) begin
      cursor_d = op_q ? lo_q : count_q;
    end
    if (ctl_i.sh_wr) begin
      cursor_d = op_q ? cur_p1 : cur_m1;
    end
    if (ctl_i.cl_cap) begin
      res_d = rdata;
    end
    if (ctl_i.finish) begin
      count_d = op_q ? count_q - 1'b1 : count_q + 1'b1;
    end
    if (ctl_i.set_st) begin
      status_d = ctl_i.st_code;
    end
  end

  // Stored count is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    cursor_q <= cursor_d;
    mid_q    <= mid_d;
    op_q     <= op_d;
    val_q    <= val_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  // Status toward the controller.
  assign sts_o.op         = op_q;
  assign sts_o.full       = (count_q == CNT_W'(CAPACITY));
  assign sts_o.more       = (lo_q < hi_q);
  assign sts_o.lo_zero    = (lo_q == '0);
  assign sts_o.shift_more = op_q ? (cursor_q < count_q) : (cursor_q > lo_q);

  assign result_o.status       = status_q;
  assign result_o.result_value = res_q;

endmodule

FILE: design/pcm_ctrl.sv
// Controller of the predecessor claim multiset unit: sequences the search,
// the claim read, the table shift and the result strobe. Depends on pcm_pkg.
module pcm_ctrl
  import pcm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  pcm_sts_t sts_i,
  output pcm_ctl_t ctl_o,
  output logic     busy,
  output logic     done_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SRD  = 7'b0000010,
    S_SCMP = 7'b0000100,
    S_CCAP = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Transition and command logic.
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_SRD;
        end
      end
      S_SRD: begin
        priority if (sts_i.op == OP_INSERT && sts_i.full) begin
          ctl_o.set_st  = 1'b1;
          ctl_o.st_code = ST_FULL;
          state_d       = S_DONE;
        end else if (sts_i.more) begin
          ctl_o.srch_rd = 1'b1;
          state_d       = S_SCMP;
        end else if (sts_i.op == OP_INSERT) begin
          ctl_o.cur_init = 1'b1;
          state_d        = S_SHRD;
        end else if (sts_i.lo_zero) begin
          ctl_o.set_st  = 1'b1;
          ctl_o.st_code = ST_NOMATCH;
          state_d       = S_DONE;
        end else begin
          ctl_o.cl_rd = 1'b1;
          state_d     = S_CCAP;
        end
      end
      S_SCMP: begin
        ctl_o.srch_cmp = 1'b1;
        state_d        = S_SRD;
      end
      S_CCAP: begin
        ctl_o.cl_cap   = 1'b1;
        ctl_o.cur_init = 1'b1;
        state_d        = S_SHRD;
      end
      S_SHRD: begin
        if (sts_i.shift_more) begin
          ctl_o.sh_rd = 1'b1;
          state_d     = S_SHWR;
        end else begin
          ctl_o.finish  = 1'b1;
          ctl_o.set_st  = 1'b1;
          ctl_o.st_code = (sts_i.op == OP_CLAIM) ? ST_MATCHED : ST_STORED;
          state_d       = S_DONE;
        end
      end
      S_SHWR: begin
        ctl_o.sh_wr = 1'b1;
        state_d     = S_SHRD;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

FILE: design/predecessor_claim_multiset_unit.sv
// Top level of the predecessor claim multiset unit.
// Instantiates pcm_ctrl and pcm_datapath; depends on pcm_pkg.

// A sorted table of up to CAPACITY 32-bit values, duplicates allowed, kept in one
// RAM. A command transfer happens when start is high and busy is low; exactly one
// result follows, shown on result_o for the single cycle in which done_o is high,
// and the receiver must take it then. Each command first runs a binary search in
// steps of a RAM read, then a compare. An insert then moves every entry above its
// place up by one and a claim moves every entry above the removed one down by one,
// each moved entry read, then written, through the single RAM port pair. A
// full-table insert skips the search and ends at once; an unmatched claim ends
// right after the search.
module predecessor_claim_multiset_unit
  import pcm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic done_o,
  output res_t result_o
);

  pcm_ctl_t ctl;
  pcm_sts_t sts;

  pcm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy),
    .done_o (done_o)
  );

  pcm_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted command makes the unit busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // The result strobe comes only while busy, and the unit is free right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy && !done_o)
    else $error("unit did not return to idle after the result");

  // Table writes never occur while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy |-> !ctl.sh_wr && !ctl.finish)
    else $error("table write while idle");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for predecessor_claim_multiset_unit.
// Predicts every result with a queue model of the sorted multiset; depends on pcm_pkg.
`timescale 1ns / 1ps

module testbench;
  import pcm_pkg::*;

  localparam int  LIMIT_CYCLES = 20_000_000;
  localparam int  RANDOM_ITEMS = 100;
  localparam int  QUIET_TAIL   = 150;
  localparam int  SETTLE       = 64;

  logic clk_i;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic done_o;
  res_t result_o;

  // Commands not yet presented, with a flag that makes the sender drain first.
  cmd_t pend_cmds[$];
  bit   pend_drain[$];
  // Results still to come, oldest first.
  res_t due_results[$];
  // Predicted table contents in ascending order.
  logic [VAL_W-1:0] table_vals[$];

  int unsigned accepted_n;
  int unsigned issued_n;
  int unsigned idle_left;
  int unsigned cycle_n;
  int unsigned errors;

  predecessor_claim_multiset_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Print one line per mismatch and count it.
  task automatic report(input string what, input logic [VAL_W-1:0] got,
                        input logic [VAL_W-1:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_n, what, got, want);
    errors++;
  endtask

  // Number of stored values that are not above the limit.
  function automatic int count_not_above(input logic [VAL_W-1:0] limit);
    int n;
    n = 0;
    while (n < table_vals.size() && table_vals[n] <= limit) n++;
    return n;
  endfunction

  // Apply one command to the predicted table and return the result it causes.
  function automatic res_t apply_command(input cmd_t c);
    res_t r;
    int   n;
    r.status       = ST_STORED;
    r.result_value = '0;
    n = count_not_above(c.value);
    if (c.operation == OP_INSERT) begin
      if (table_vals.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        table_vals.insert(n, c.value);
      end
    end else if (n == 0) begin
      r.status = ST_NOMATCH;
    end else begin
      r.status       = ST_MATCHED;
      r.result_value = table_vals[n-1];
      table_vals.delete(n-1);
    end
    return r;
  endfunction

  task automatic push_cmd(input logic op, input logic [VAL_W-1:0] v, input bit drain);
    cmd_t c;
    c.operation = op;
    c.value     = v;
    pend_cmds.push_back(c);
    pend_drain.push_back(drain);
  endtask

  // Monitor: count transfers, predict, and check results at the rising edge.
  always @(posedge clk_i) begin
    res_t want;
    cycle_n <= cycle_n + 1;
    if (cycle_n > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_n);
      $display("Verification failed");
      $finish;
    end else if (rst_ni) begin
      if (start && !busy) begin
        due_results.push_back(apply_command(cmd_i));
        accepted_n <= accepted_n + 1;
      end
      if (done_o) begin
        if (due_results.size() == 0) begin
          report("unexpected result, status", VAL_W'(result_o.status), '0);
        end else begin
          want = due_results.pop_front();
          if (result_o.status !== want.status)
            report("status", VAL_W'(result_o.status), VAL_W'(want.status));
          if (result_o.result_value !== want.result_value)
            report("result_value", result_o.result_value, want.result_value);
        end
      end
    end
  end

  // Driver: present the next command at the falling edge once the last was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || accepted_n == issued_n)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (pend_cmds.size() > 0 &&
                   !(pend_drain[0] && (due_results.size() != 0 || start))) begin
        cmd_i <= pend_cmds.pop_front();
        void'(pend_drain.pop_front());
        start    <= 1'b1;
        issued_n <= issued_n + 1;
        if (pend_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          idle_left <= $urandom_range(1, 13);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [VAL_W-1:0] v;
    int               live;
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = '0;
    accepted_n = 0;
    issued_n   = 0;
    idle_left  = 0;
    cycle_n    = 0;
    errors     = 0;

    // Directed: extremes, duplicates, empty table and no-fit claims.
    push_cmd(OP_CLAIM, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_INSERT, 32'h0, 1'b0);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, 32'h0, 1'b0);
    push_cmd(OP_CLAIM, 32'h0, 1'b0);
    push_cmd(OP_INSERT, 32'd5, 1'b0);
    push_cmd(OP_INSERT, 32'd5, 1'b0);
    push_cmd(OP_INSERT, 32'd5, 1'b0);
    push_cmd(OP_CLAIM, 32'd4, 1'b0);
    push_cmd(OP_CLAIM, 32'd5, 1'b0);
    push_cmd(OP_CLAIM, 32'hFFFF_FFFE, 1'b0);
    push_cmd(OP_INSERT, 32'h8000_0000, 1'b0);
    push_cmd(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, 32'h7FFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, 32'hFFFF_FFFF, 1'b0);

    // Fill the table with rising values so few entries move, then overflow it.
    v = 32'h10;
    for (int i = 0; i < CAPACITY; i++) begin
      v = v + $urandom_range(0, 3);
      push_cmd(OP_INSERT, v, i == 0);
    end
    push_cmd(OP_INSERT, 32'h0, 1'b1);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_CLAIM, v, 1'b0);
    push_cmd(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    push_cmd(OP_INSERT, 32'h0, 1'b0);

    // Random part: the table starts full and claims dominate, so full inserts and
    // long shifts both occur; values are drawn from a narrow pool, which hits the low
    // end of the table, from just below the maximum, or from the full range.
    live = CAPACITY;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      logic op;
      op = (live > 48) ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 1) != 0);
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = 32'hFFFF_FFFF - $urandom_range(0, 20);
        default: v = $urandom_range(0, 40);
      endcase
      if (op == OP_INSERT) live++;
      else if (live > 0) live--;
      push_cmd(op, v, i == RANDOM_ITEMS / 2);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_cmds.size() != 0 || start) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (errors == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
